// File: hdl/smmh_pkg.sv
// ----------------------------------------------------------------------------
// smmh_pkg - shared types and constants for the string multiply-mix hash
// seeds, mixing masks, sequencer states and the control bundle that the
// sequencer hands to the datapath
// ----------------------------------------------------------------------------
package smmh_pkg;

    // state seeds
    localparam logic [31:0] KEY_SEED   = 32'hF4FA8928;
    localparam logic [31:0] LANE1_SEED = 32'h37A8470E;
    localparam logic [31:0] LANE2_SEED = 32'h7758B42B;

    // key whitening and multiplier masks
    localparam logic [31:0] KEY_XOR = 32'h267B0B11;
    localparam logic [31:0] M1_SET  = 32'h02040801;
    localparam logic [31:0] M1_KEEP = 32'hBFEF7FDF;
    localparam logic [31:0] M2_SET  = 32'h00804021;
    localparam logic [31:0] M2_KEEP = 32'h7DFEFBFF;

    // words mixed after the string ends
    localparam logic [31:0] FINAL_ONE = 32'h9BE74448;
    localparam logic [31:0] FINAL_TWO = 32'h66F42C48;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL1,
        S_FOLD1,
        S_FOLD2,
        S_DONE
    } state_t;

    // which word the current round mixes
    typedef enum logic [1:0] {
        W_DATA,
        W_FIN1,
        W_FIN2
    } word_sel_t;

    // per-cycle controls from the sequencer
    typedef struct packed {
        logic idle;
        logic load;
        logic mul_first;
        logic fold_first;
        logic fold_second;
        logic done;
    } ctl_t;

endpackage

// File: hdl/smmh_mul.sv
// ----------------------------------------------------------------------------
// smmh_mul - shared 32x32 multiplier
// unsigned full product, registered, loaded when enabled
// ----------------------------------------------------------------------------
module smmh_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign prod_next = {32'h0, op_a} * {32'h0, op_b};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: hdl/smmh_fsm.sv
// ----------------------------------------------------------------------------
// smmh_fsm - round sequencer
// steps one mixing round through load, two multiplies and two folds, then
// chains the closing rounds and waits for the output register
// ----------------------------------------------------------------------------
module smmh_fsm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           last_round,
    input  logic           round_more,
    input  logic           out_free,
    output smmh_pkg::ctl_t ctl
);

    import smmh_pkg::*;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:  state_next = S_MUL1;
            S_MUL1:  state_next = S_FOLD1;
            S_FOLD1: state_next = S_FOLD2;
            S_FOLD2:
            begin
                if (last_round)
                begin
                    state_next = S_DONE;
                end
                else if (round_more)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // controls
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            S_IDLE:  ctl.idle        = 1'b1;
            S_LOAD:  ctl.load        = 1'b1;
            S_MUL1:  ctl.mul_first   = 1'b1;
            S_FOLD1: ctl.fold_first  = 1'b1;
            S_FOLD2: ctl.fold_second = 1'b1;
            S_DONE:  ctl.done        = 1'b1;
            default: ctl = '0;
        endcase
    end

endmodule

// File: hdl/string_multiply_mix_hash_core.sv
// ----------------------------------------------------------------------------
// string_multiply_mix_hash_core - streaming two-lane multiply-mix string hash
// packs string bytes into little-endian words, mixes each full word through
// one shared multiplier, and closes the string with two constant rounds
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// -------   ---------  -------------------  --------------------------
// input     in         in_valid / in_stall  data_byte  [7:0]
// output    out        out_valid / out_stall hash_value [31:0]
//
// a byte that does not complete a word is simply packed; a byte that completes
// a word also starts a round (load, multiply, fold, fold)
// the zero byte runs two or three rounds and then loads the result;
// the rate is set by the single shared multiplier
// reset (async, active low) puts the key and lanes at their seeds and idles
// in_stall is high whenever a round is running or a result waits to load;
// out_stall holds the result register; bytes keep flowing until a result waits to load
//
module string_multiply_mix_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    import smmh_pkg::*;

    ctl_t ctl;

    // hash state
    logic [31:0] key_reg,     key_next;
    logic [31:0] lane1_reg,   lane1_next;
    logic [31:0] lane2_reg,   lane2_next;
    logic [23:0] pending_reg, pending_next;
    logic [1:0]  pos_reg,     pos_next;

    // round working registers
    logic [31:0] word_reg,    word_next;
    logic [31:0] m2_reg,      m2_next;
    word_sel_t   sel_reg,     sel_next;
    logic        final_reg,   final_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] hash_reg,      hash_next;

    logic        in_accept;
    logic        start;
    logic        out_free;
    logic        last_round;
    logic        round_more;

    logic [31:0] key_word;
    logic [31:0] m1;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [31:0] prod_lo;
    logic [31:0] prod_hi;
    logic [32:0] f1_sum;
    logic [31:0] f1_val;
    logic [32:0] f2_sum;
    logic [31:0] f2_val;

    assign in_stall  = ~ctl.idle;
    assign in_accept = in_valid & ~in_stall;

    // a round starts on the string end or on the byte that fills a word
    assign start    = in_accept & ((data_byte == 8'h00) | (pos_reg == 2'd3));
    assign out_free = ~out_valid_reg | ~out_stall;

    // closing-round chain
    assign last_round = final_reg & (sel_reg == W_FIN2);
    assign round_more = final_reg;

    // multiplier operands: first lane in MUL1, second lane in FOLD1
    assign key_word = KEY_XOR ^ key_reg;
    assign m1       = ((key_word + lane2_reg) | M1_SET) & M1_KEEP;
    assign mul_a    = ctl.fold_first ? lane2_reg : lane1_reg;
    assign mul_b    = ctl.fold_first ? m2_reg : m1;

    assign prod_lo = prod[31:0];
    assign prod_hi = prod[63:32];

    // first lane fold: high half plus a carry when it is nonzero, end-around
    assign f1_sum = {1'b0, prod_lo} + {1'b0, prod_hi} + {32'h0, (prod_hi != 32'h0)};
    assign f1_val = f1_sum[31:0] + {31'h0, f1_sum[32]};

    // second lane fold: doubled high half with its top bit wrapped in
    assign f2_sum = {1'b0, prod_lo} + {1'b0, prod_hi[30:0], 1'b0} + {32'h0, prod_hi[31]};
    assign f2_val = f2_sum[31:0] + (f2_sum[32] ? 32'd2 : 32'd0);

    smmh_mul u_mul (
        .clk  (clk),
        .en   (ctl.mul_first | ctl.fold_first),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    smmh_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_round (last_round),
        .round_more (round_more),
        .out_free   (out_free),
        .ctl        (ctl)
    );

    always_comb
    begin
        key_next       = key_reg;
        lane1_next     = lane1_reg;
        lane2_next     = lane2_reg;
        pending_next   = pending_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        m2_next        = m2_reg;
        sel_next       = sel_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        hash_next      = hash_reg;

        // byte intake
        if (in_accept)
        begin
            if (data_byte != 8'h00 && pos_reg != 2'd3)
            begin
                // still filling the word
                pending_next = pending_reg | ({16'h0, data_byte} << {pos_reg, 3'b000});
                pos_next     = pos_reg + 2'd1;
            end
            else if (data_byte != 8'h00)
            begin
                // word complete
                word_next    = {data_byte, pending_reg};
                sel_next     = W_DATA;
                final_next   = 1'b0;
                pending_next = 24'h0;
                pos_next     = 2'd0;
            end
            else
            begin
                // string end: mix a partial word only if one is held
                final_next   = 1'b1;
                pending_next = 24'h0;
                pos_next     = 2'd0;
                if (pos_reg != 2'd0)
                begin
                    word_next = {8'h00, pending_reg};
                    sel_next  = W_DATA;
                end
                else
                begin
                    word_next = FINAL_ONE;
                    sel_next  = W_FIN1;
                end
            end
        end

        // rotate key, absorb word into both lanes
        if (ctl.load)
        begin
            key_next   = {key_reg[30:0], key_reg[31]};
            lane1_next = lane1_reg ^ word_reg;
            lane2_next = lane2_reg ^ word_reg;
        end

        // second multiplier uses lane one before it is folded
        if (ctl.mul_first)
        begin
            m2_next = ((key_word + lane1_reg) | M2_SET) & M2_KEEP;
        end

        if (ctl.fold_first)
        begin
            lane1_next = f1_val;
        end

        // finish the round and queue the next closing word
        if (ctl.fold_second)
        begin
            lane2_next = f2_val;
            if (final_reg)
            begin
                case (sel_reg)
                    W_DATA:
                    begin
                        word_next = FINAL_ONE;
                        sel_next  = W_FIN1;
                    end
                    W_FIN1:
                    begin
                        word_next = FINAL_TWO;
                        sel_next  = W_FIN2;
                    end
                    default: sel_next = sel_reg;
                endcase
            end
        end

        // result handoff, then back to the seeds
        if (ctl.done && out_free)
        begin
            out_valid_next = 1'b1;
            hash_next      = lane1_reg ^ lane2_reg;
            key_next       = KEY_SEED;
            lane1_next     = LANE1_SEED;
            lane2_next     = LANE2_SEED;
            final_next     = 1'b0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= KEY_SEED;
            lane1_reg     <= LANE1_SEED;
            lane2_reg     <= LANE2_SEED;
            pending_reg   <= 24'h0;
            pos_reg       <= 2'd0;
            sel_reg       <= W_DATA;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_reg       <= key_next;
            lane1_reg     <= lane1_next;
            lane2_reg     <= lane2_next;
            pending_reg   <= pending_next;
            pos_reg       <= pos_next;
            sel_reg       <= sel_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        m2_reg   <= m2_next;
        hash_reg <= hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // a string end always starts the closing rounds
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && data_byte == 8'h00) |=> (in_stall && final_reg))
        else $error("string end did not start closing rounds");

    // byte packing is empty while a round runs
    assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.idle |-> (pos_reg == 2'd0 && pending_reg == 24'h0))
        else $error("pending bytes held during a round");

    // result load returns the hash state to its seeds
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.done && out_free) |=> (out_valid && key_reg == KEY_SEED
            && lane1_reg == LANE1_SEED && lane2_reg == LANE2_SEED && !final_reg))
        else $error("state not reseeded after result");

    // a full word round never chains into another round
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fold_second && !final_reg) |=> ctl.idle)
        else $error("data round did not return to idle");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for string_multiply_mix_hash_core
// feeds zero-terminated byte strings through the request channel, predicts
// each hash with a local model of the two-lane multiply-mix rounds, and checks
// every hash that leaves the block, in order, under random and long stalls
// ----------------------------------------------------------------------------
module testbench;

    import smmh_pkg::*;

    // cycles with no request accepted on either side before the run is abandoned
    localparam int IDLE_LIMIT = 4000;
    // settle time after the last hash
    localparam int DRAIN_CYCLES = 32;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] hash_value;

    string_multiply_mix_hash_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    // hash predictor state, kept in step with every accepted byte
    logic [31:0] rot_key;
    logic [31:0] lane1;
    logic [31:0] lane2;
    logic [23:0] held_bytes;
    logic [1:0]  held_count;

    // hashes predicted but not yet seen at the output, oldest first
    logic [31:0] pending_hashes[$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        out_stall = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // seeds, as after reset and after every finished string
    task automatic clear_hash_state();
        rot_key    = KEY_SEED;
        lane1      = LANE1_SEED;
        lane2      = LANE2_SEED;
        held_bytes = '0;
        held_count = '0;
    endtask

    // one mixing round on a 32-bit word; returns the new second lane
    function automatic logic [31:0] mix_word(input logic [31:0] word);
        logic [31:0] k;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] t;
        logic        c;
        logic [63:0] prod;
        logic [63:0] sum;

        rot_key = {rot_key[30:0], rot_key[31]};
        k       = KEY_XOR ^ rot_key;
        lane1   = lane1 ^ word;
        lane2   = lane2 ^ word;

        // first lane: fold high half back in, plus a carry when it is nonzero
        m1   = ((k + lane2) | M1_SET) & M1_KEEP;
        prod = {32'd0, lane1} * {32'd0, m1};
        lo   = prod[31:0];
        hi   = prod[63:32];
        c    = (hi != 32'd0);
        sum  = {32'd0, lo} + {32'd0, hi} + {63'd0, c};
        lo   = sum[31:0];
        c    = sum[32];
        sum  = {32'd0, lo} + {63'd0, c};
        // second multiplier uses the first lane before it is replaced
        m2    = ((k + lane1) | M2_SET) & M2_KEEP;
        lane1 = sum[31:0];

        // second lane: doubled high half, its top bit as carry, +2 on overflow
        prod = {32'd0, lane2} * {32'd0, m2};
        lo   = prod[31:0];
        hi   = prod[63:32];
        c    = hi[31];
        sum  = {32'd0, lo} + {32'd0, hi << 1} + {63'd0, c};
        t    = sum[31:0];
        if (sum[63:32] != 32'd0)
        begin
            t = t + 32'd2;
        end
        lane2 = t;
        return t;
    endfunction

    // advance the model by one byte; a zero byte closes the string
    task automatic predict_byte(input logic [7:0] b);
        logic [31:0] last;

        if (b != 8'h00)
        begin
            if (held_count == 2'd3)
            begin
                void'(mix_word({b, held_bytes}));
                held_bytes = '0;
                held_count = '0;
            end
            else
            begin
                held_bytes[8*held_count +: 8] = b;
                held_count = held_count + 2'd1;
            end
        end
        else
        begin
            // empty string or word boundary: no partial round
            if (held_count != 2'd0)
            begin
                void'(mix_word({8'h00, held_bytes}));
            end
            void'(mix_word(FINAL_ONE));
            last = mix_word(FINAL_TWO);
            pending_hashes.push_back(last ^ lane1);
            clear_hash_state();
        end
    endtask

    initial
    begin
        clear_hash_state();
    end

    // every byte the block takes goes through the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_byte(data_byte);
        end
    end

    // ------------------------------------------------------------------------
    // result side: check each accepted hash, drive random or long stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hashes.size() == 0)
            begin
                $display("%0t: unexpected hash, expected none, got %08h", $time, hash_value);
                error_count++;
            end
            else if (hash_value !== pending_hashes[0])
            begin
                $display("%0t: hash mismatch, expected %08h, got %08h",
                         $time, pending_hashes[0], hash_value);
                error_count++;
                void'(pending_hashes.pop_front());
            end
            else
            begin
                void'(pending_hashes.pop_front());
            end
        end

        // a long hold-off is counted down here, cycle by cycle
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: abandon the run when neither channel moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("** string_multiply_mix_hash_core: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offer one byte, with random idle cycles first; returns on acceptance
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_string(input int len);
        repeat (len)
        begin
            send_byte(8'($urandom_range(255, 1)));
        end
        send_byte(8'h00);
    endtask

    // stop offering and wait until every predicted hash has been checked
    task automatic wait_for_hashes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hashes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // byte extremes, empty string, partial words of each length, exact words
    task automatic test_directed();
        send_byte(8'h00);                 // empty string
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h80);                 // three bytes, padded partial word
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h00);
        repeat (4)                        // exactly one word, no partial round
        begin
            send_byte(8'hFF);
        end
        send_byte(8'h00);
        send_byte(8'h01);                 // one word then a two-byte tail
        send_byte(8'h02);
        send_byte(8'h04);
        send_byte(8'h08);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h00);
        wait_for_hashes();
    endtask

    // random strings, mostly short, some spanning many words
    task automatic test_random_strings(input int n_bytes);
        int sent;
        int len;

        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(9) == 0)
            begin
                len = $urandom_range(40, 12);
            end
            else
            begin
                len = $urandom_range(11);
            end
            send_string(len);
            sent += len + 1;
        end
        wait_for_hashes();
    endtask

    // receiver holds off while short strings keep coming, so the result
    // register fills and the block must stall the bytes after the next zero byte
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 300;
        repeat (8)
        begin
            send_string($urandom_range(5));
        end
        wait_for_hashes();
    endtask

    initial
    begin
        error_count   = 0;
        hold_request  = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        send_idle_pct = 11;
        recv_idle_pct = 77;
        wait (rst_n === 1'b1);
        @(posedge clk);

        test_directed();
        test_random_strings(130);
        test_result_backpressure();

        send_idle_pct = 77;
        recv_idle_pct = 11;
        test_random_strings(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(140);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_hashes.size() == 0)
        begin
            $display("** string_multiply_mix_hash_core: PASSED **");
        end
        else
        begin
            $display("** string_multiply_mix_hash_core: FAILED **");
        end
        $finish;
    end

endmodule
